// File: src/fixed_block_pool_allocator_macros.svh
// Assertion macros for the block pool allocator checker.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// Check a property on every rising edge outside reset.
`define FBPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define FBPA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/fbpa_pkg.sv
`default_nettype none

package fbpa_pkg;

    localparam int OFFSET_W    = 23;
    localparam int INDEX_W     = 6;
    localparam int COUNT_W     = 7;
    localparam int BYTES_W     = 16;
    localparam int STATUS_W    = 2;
    localparam int STRIDE_W    = 17;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam int DEF_MAX_BLOCKS    = 64;
    localparam int DEF_HEADER_BYTES  = 8;
    localparam int RESET_BLOCK_COUNT = 64;
    localparam int RESET_BLOCK_BYTES = 100;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK          = 2'd0,
        STATUS_EMPTY       = 2'd1,
        STATUS_BAD_RELEASE = 2'd2
    } status_t;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_BYTES = 1'b1;

    // Handshake between the top level and the serial divider.
    typedef struct packed {
        logic start;
        logic done;
    } div_ctrl_t;

endpackage

`default_nettype wire

// File: src/fbpa_divider.sv
`default_nettype none

// Restoring divider: one quotient bit per cycle, MSB first.
module fbpa_divider #(
    parameter int DIVIDEND_W = fbpa_pkg::OFFSET_W,
    parameter int DIVISOR_W  = fbpa_pkg::STRIDE_W
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire fbpa_pkg::div_ctrl_t   ctrl_in,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output fbpa_pkg::div_ctrl_t        ctrl_out,
    output logic [DIVIDEND_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  running_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [DIVIDEND_W-1:0] quo_reg;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff    = shifted - {1'b0, divisor_reg};
        fits    = ~diff[DIVISOR_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
            rem_reg     <= '0;
            divisor_reg <= '0;
            quo_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl_in.start)
            begin
                running_reg <= 1'b1;
                cnt_reg     <= CNT_W'(DIVIDEND_W);
                rem_reg     <= '0;
                divisor_reg <= divisor;
                quo_reg     <= dividend;
            end
            else if (running_reg)
            begin
                // shift the next dividend bit into the remainder, subtract if it fits
                rem_reg <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    running_reg <= 1'b0;
                    done_reg    <= 1'b1;
                end
            end
        end
    end

    assign ctrl_out.start = running_reg;
    assign ctrl_out.done  = done_reg;
    assign quotient       = quo_reg;

endmodule

`default_nettype wire

// File: src/fixed_block_pool_allocator.sv
`default_nettype none

// Channel   Handshake              Payload
// command   start / busy           command, release_offset
// result    done (one-cycle pulse) status, block_index, user_offset, free_blocks
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Allocate: result after the free-list read in S_FETCH and the
// one-bit-per-cycle shift-add of index times stride in S_MUL.
// Allocate on an empty pool: result on the next cycle.
// Release: result set by the 23-step serial divider, waited for in S_DIV.
// Reset and each config write restore the full free list and clear the map.
// done is never held off; read the result ports in the cycle done is high.
module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS   = fbpa_pkg::DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = fbpa_pkg::DEF_HEADER_BYTES
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             command,
    input  wire logic [fbpa_pkg::OFFSET_W-1:0]    release_offset,
    output logic                                  done,
    output logic [fbpa_pkg::STATUS_W-1:0]         status,
    output logic [fbpa_pkg::INDEX_W-1:0]          block_index,
    output logic [fbpa_pkg::OFFSET_W-1:0]         user_offset,
    output logic [fbpa_pkg::COUNT_W-1:0]          free_blocks,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [fbpa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int MW = $clog2(IW + 1);
    localparam int OW = fbpa_pkg::OFFSET_W;
    localparam int SW = fbpa_pkg::STRIDE_W;
    localparam int RESET_N = (fbpa_pkg::RESET_BLOCK_COUNT > MAX_BLOCKS) ?
                             MAX_BLOCKS : fbpa_pkg::RESET_BLOCK_COUNT;
    localparam logic [CW-1:0] RESET_COUNT  = CW'(RESET_N);
    localparam logic [IW-1:0] RESET_TAIL   = IW'((RESET_N == MAX_BLOCKS) ? 0 : RESET_N);
    localparam logic [SW-1:0] RESET_STRIDE =
        SW'(fbpa_pkg::RESET_BLOCK_BYTES + HEADER_BYTES);
    localparam logic [IW-1:0] LAST_SLOT    = IW'(MAX_BLOCKS - 1);
    localparam logic [CW-1:0] FULL_COUNT   = CW'(MAX_BLOCKS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_MUL,
        S_DIV
    } state_t;

    state_t                        state_reg, state_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [SW-1:0]                 stride_reg, stride_next;
    logic [IW-1:0]                 head_reg, head_next;
    logic [IW-1:0]                 tail_reg, tail_next;
    logic [CW-1:0]                 free_reg, free_next;
    logic [MAX_BLOCKS-1:0]         map_reg, map_next;
    logic [MAX_BLOCKS-1:0]         qvalid_reg, qvalid_next;
    logic [IW-1:0]                 idx_reg, idx_next;
    logic [IW-1:0]                 mul_shift_reg, mul_shift_next;
    logic [MW-1:0]                 mul_cnt_reg, mul_cnt_next;
    logic [OW-1:0]                 acc_reg, acc_next;
    logic                          done_reg, done_next;
    fbpa_pkg::status_t             status_reg, status_next;
    logic [fbpa_pkg::INDEX_W-1:0]  index_reg, index_next;
    logic [OW-1:0]                 user_reg, user_next;
    logic [fbpa_pkg::COUNT_W-1:0]  free_out_reg, free_out_next;

    // free list storage
    logic [IW-1:0]                 queue_mem [MAX_BLOCKS];
    logic [IW-1:0]                 rd_data_reg;
    logic                          rd_valid_reg;
    logic [IW-1:0]                 rd_addr_reg;
    logic                          rd_en;
    logic                          wr_en;
    logic [IW-1:0]                 wr_data;

    logic                          cfg_fire;
    logic [fbpa_pkg::COUNT_W-1:0]  cfg_raw_count;
    logic [fbpa_pkg::BYTES_W-1:0]  cfg_raw_bytes;
    logic [CW-1:0]                 cfg_count;
    logic [SW-1:0]                 cfg_stride;
    logic [CW-1:0]                 init_count;

    fbpa_pkg::div_ctrl_t           div_in;
    fbpa_pkg::div_ctrl_t           div_out;
    logic [OW-1:0]                 quotient;

    logic [IW-1:0]                 fetch_idx;
    logic [OW-1:0]                 acc_step;
    logic                          in_range;
    logic [IW-1:0]                 rel_slot;

    function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] p);
        next_slot = (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    fbpa_divider #(
        .DIVIDEND_W (OW),
        .DIVISOR_W  (SW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (div_in),
        .dividend (release_offset),
        .divisor  (stride_reg),
        .ctrl_out (div_out),
        .quotient (quotient)
    );

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !start;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_comb
    begin
        cfg_raw_count = cfg_data[fbpa_pkg::COUNT_W-1:0];
        cfg_raw_bytes = cfg_data[fbpa_pkg::BYTES_W-1:0];
        if (cfg_raw_count == '0)
            cfg_count = CW'(1);
        else if (32'(cfg_raw_count) > 32'(MAX_BLOCKS))
            cfg_count = FULL_COUNT;
        else
            cfg_count = CW'(cfg_raw_count);
        cfg_stride = ((cfg_raw_bytes == '0) ? SW'(1) : SW'(cfg_raw_bytes))
                     + SW'(HEADER_BYTES);
    end

    always_comb
    begin
        fetch_idx = rd_valid_reg ? rd_data_reg : rd_addr_reg;
        acc_step  = OW'({acc_reg, 1'b0})
                    + (mul_shift_reg[IW-1] ? OW'(stride_reg) : '0);
        in_range  = quotient < OW'(count_reg);
        rel_slot  = quotient[IW-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        stride_next    = stride_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_next      = free_reg;
        map_next       = map_reg;
        qvalid_next    = qvalid_reg;
        idx_next       = idx_reg;
        mul_shift_next = mul_shift_reg;
        mul_cnt_next   = mul_cnt_reg;
        acc_next       = acc_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        index_next     = index_reg;
        user_next      = user_reg;
        free_out_next  = free_out_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_data        = rel_slot;
        div_in.start   = 1'b0;
        div_in.done    = 1'b0;
        init_count     = count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_fire)
                begin
                    case (cfg_index)
                        fbpa_pkg::REG_BLOCK_COUNT:
                        begin
                            count_next = cfg_count;
                            init_count = cfg_count;
                        end
                        fbpa_pkg::REG_BLOCK_BYTES:
                        begin
                            stride_next = cfg_stride;
                        end
                        default:
                        begin
                        end
                    endcase
                    // rebuild the pool: full free list, nothing allocated
                    head_next   = '0;
                    tail_next   = (init_count == FULL_COUNT) ? '0 : IW'(init_count);
                    free_next   = init_count;
                    map_next    = '0;
                    qvalid_next = '0;
                end
                else if (start)
                begin
                    if (command == fbpa_pkg::CMD_ALLOC)
                    begin
                        if (free_reg == '0)
                        begin
                            done_next     = 1'b1;
                            status_next   = fbpa_pkg::STATUS_EMPTY;
                            index_next    = '0;
                            user_next     = '0;
                            free_out_next = fbpa_pkg::COUNT_W'(free_reg);
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            head_next  = next_slot(head_reg);
                            free_next  = free_reg - 1'b1;
                            state_next = S_FETCH;
                        end
                    end
                    else
                    begin
                        div_in.start = 1'b1;
                        state_next   = S_DIV;
                    end
                end
            end

            S_FETCH:
            begin
                idx_next            = fetch_idx;
                mul_shift_next      = fetch_idx;
                mul_cnt_next        = MW'(IW);
                acc_next            = '0;
                map_next[fetch_idx] = 1'b1;
                state_next          = S_MUL;
            end

            S_MUL:
            begin
                acc_next       = acc_step;
                mul_shift_next = mul_shift_reg << 1;
                mul_cnt_next   = mul_cnt_reg - 1'b1;
                if (mul_cnt_reg == MW'(1))
                begin
                    done_next     = 1'b1;
                    status_next   = fbpa_pkg::STATUS_OK;
                    index_next    = fbpa_pkg::INDEX_W'(idx_reg);
                    user_next     = acc_step + OW'(HEADER_BYTES);
                    free_out_next = fbpa_pkg::COUNT_W'(free_reg);
                    state_next    = S_IDLE;
                end
            end

            S_DIV:
            begin
                if (div_out.done)
                begin
                    done_next  = 1'b1;
                    user_next  = '0;
                    state_next = S_IDLE;
                    if (in_range && map_reg[rel_slot])
                    begin
                        map_next[rel_slot]    = 1'b0;
                        wr_en                 = 1'b1;
                        qvalid_next[tail_reg] = 1'b1;
                        tail_next             = next_slot(tail_reg);
                        free_next             = free_reg + 1'b1;
                        status_next           = fbpa_pkg::STATUS_OK;
                        index_next            = fbpa_pkg::INDEX_W'(rel_slot);
                        free_out_next         = fbpa_pkg::COUNT_W'(free_reg + 1'b1);
                    end
                    else
                    begin
                        status_next   = fbpa_pkg::STATUS_BAD_RELEASE;
                        index_next    = '0;
                        free_out_next = fbpa_pkg::COUNT_W'(free_reg);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= RESET_COUNT;
            stride_reg    <= RESET_STRIDE;
            head_reg      <= '0;
            tail_reg      <= RESET_TAIL;
            free_reg      <= RESET_COUNT;
            map_reg       <= '0;
            qvalid_reg    <= '0;
            idx_reg       <= '0;
            mul_shift_reg <= '0;
            mul_cnt_reg   <= '0;
            acc_reg       <= '0;
            done_reg      <= 1'b0;
            status_reg    <= fbpa_pkg::STATUS_OK;
            index_reg     <= '0;
            user_reg      <= '0;
            free_out_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            stride_reg    <= stride_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_reg      <= free_next;
            map_reg       <= map_next;
            qvalid_reg    <= qvalid_next;
            idx_reg       <= idx_next;
            mul_shift_reg <= mul_shift_next;
            mul_cnt_reg   <= mul_cnt_next;
            acc_reg       <= acc_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
            index_reg     <= index_next;
            user_reg      <= user_next;
            free_out_reg  <= free_out_next;
        end
    end

    // An entry never written since the last rebuild is read as its own index.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            queue_mem[tail_reg] <= wr_data;
        if (rd_en)
        begin
            rd_data_reg  <= queue_mem[head_reg];
            rd_valid_reg <= qvalid_reg[head_reg];
            rd_addr_reg  <= head_reg;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign block_index = index_reg;
    assign user_offset = user_reg;
    assign free_blocks = free_out_reg;

endmodule

`default_nettype wire

// File: src/fbpa_checker.sv
`default_nettype none

`include "fixed_block_pool_allocator_macros.svh"

module fbpa_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          done,
    input wire logic [fbpa_pkg::STATUS_W-1:0] status,
    input wire logic [fbpa_pkg::INDEX_W-1:0]  block_index,
    input wire logic [fbpa_pkg::OFFSET_W-1:0] user_offset,
    input wire logic [fbpa_pkg::COUNT_W-1:0]  free_blocks
);

    `FBPA_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> (!busy && !done), "busy or done during reset")

    `FBPA_ASSERT(a_start_progress, (start && !busy) |=> (busy || done), "transaction accepted but dropped")

    `FBPA_ASSERT(a_empty_no_free, (done && status == fbpa_pkg::STATUS_EMPTY) |-> (free_blocks == '0), "empty reported with free blocks")

    `FBPA_ASSERT(a_fail_zero_payload, (done && status != fbpa_pkg::STATUS_OK) |-> (block_index == '0 && user_offset == '0), "failed transaction carries payload")

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .block_index (block_index),
    .user_offset (user_offset),
    .free_blocks (free_blocks)
);

`default_nettype wire
